[hdl/fkat_pkg.sv]
// Package: shared types, constants and command/status structs of the flow table.
`timescale 1ns / 1ps
package fkat_pkg;
  localparam int TableDepth = 256;
  localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW = $clog2(TableDepth + 1);

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_DRAINED  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  localparam logic [0:0] REG_SCALE_A = 1'b0;
  localparam logic [0:0] REG_SCALE_B = 1'b1;

  typedef struct packed {
    logic            load;       // capture input item
    logic            mul_hi;     // register the four 32x32 partial products
    logic            rd_en;      // read entry at rd_idx
    logic [IdxW-1:0] rd_idx;
    logic            wr_en;      // write entry at wr_idx
    logic [IdxW-1:0] wr_idx;
    logic            wr_insert;  // write key and scaled values (else add)
    logic            res_load;   // capture a result
    status_t         res_status;
  } fkat_cmd_t;

  typedef struct packed {
    logic key_match;  // registered entry read matches held key
  } fkat_sts_t;

  typedef struct packed {
    logic        action;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] value_a;
    logic [63:0] value_b;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_key_high;
    logic [63:0] out_key_low;
    logic [63:0] total_a;
    logic [63:0] total_b;
  } result_t;
endpackage

[hdl/fkat_stream_if.sv]
// Interface: valid/ready channel carrying one payload.
`timescale 1ns / 1ps
interface fkat_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/fkat_datapath.sv]
// Datapath: item hold, scaled products, entry memory and result register.
`timescale 1ns / 1ps
module fkat_datapath
  import fkat_pkg::*;
(
  input  logic        clk,
  input  item_t       item,
  input  logic [31:0] scale_a,
  input  logic [31:0] scale_b,
  input  fkat_cmd_t   cmd,
  output fkat_sts_t   sts,
  output result_t     result
);
  logic [63:0] key_high, key_low, value_a, value_b;
  logic [63:0] da, db;
  logic [63:0] pa_lo, pb_lo;
  logic [31:0] pa_hi, pb_hi;

  logic [63:0] mem_kh [TableDepth];
  logic [63:0] mem_kl [TableDepth];
  logic [63:0] mem_ta [TableDepth];
  logic [63:0] mem_tb [TableDepth];
  logic [63:0] rd_kh, rd_kl, rd_ta, rd_tb;
  logic [63:0] sum_a, sum_b;

  // 64x32 product mod 2^64 from two 32x32 halves, registered on mul_hi
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_high <= item.key_high;
      key_low  <= item.key_low;
      value_a  <= item.value_a;
      value_b  <= item.value_b;
    end
    if (cmd.mul_hi) begin
      pa_lo <= value_a[31:0] * scale_a;
      pb_lo <= value_b[31:0] * scale_b;
      pa_hi <= value_a[63:32] * scale_a;
      pb_hi <= value_b[63:32] * scale_b;
    end
  end

  assign da = pa_lo + {pa_hi, 32'd0};
  assign db = pb_lo + {pb_hi, 32'd0};
  assign sum_a = rd_ta + da;
  assign sum_b = rd_tb + db;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_kh <= mem_kh[cmd.rd_idx];
      rd_kl <= mem_kl[cmd.rd_idx];
      rd_ta <= mem_ta[cmd.rd_idx];
      rd_tb <= mem_tb[cmd.rd_idx];
    end
    if (cmd.wr_en) begin
      mem_kh[cmd.wr_idx] <= key_high;
      mem_kl[cmd.wr_idx] <= key_low;
      mem_ta[cmd.wr_idx] <= cmd.wr_insert ? da : sum_a;
      mem_tb[cmd.wr_idx] <= cmd.wr_insert ? db : sum_b;
    end
  end

  assign sts.key_match = (rd_kh == key_high) && (rd_kl == key_low);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result.status <= cmd.res_status;
      case (cmd.res_status)
        ST_UPDATED: begin
          result.out_key_high <= key_high;
          result.out_key_low  <= key_low;
          result.total_a      <= sum_a;
          result.total_b      <= sum_b;
        end
        ST_INSERTED: begin
          result.out_key_high <= key_high;
          result.out_key_low  <= key_low;
          result.total_a      <= da;
          result.total_b      <= db;
        end
        ST_FULL: begin
          result.out_key_high <= key_high;
          result.out_key_low  <= key_low;
          result.total_a      <= '0;
          result.total_b      <= '0;
        end
        ST_DRAINED: begin
          result.out_key_high <= rd_kh;
          result.out_key_low  <= rd_kl;
          result.total_a      <= rd_ta;
          result.total_b      <= rd_tb;
        end
        default: begin
          result.out_key_high <= '0;
          result.out_key_low  <= '0;
          result.total_a      <= '0;
          result.total_b      <= '0;
        end
      endcase
    end
  end
endmodule

[hdl/fkat_controller.sv]
// Controller: scan sequencer, valid bits and handshake control.
`timescale 1ns / 1ps
module fkat_controller
  import fkat_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_action,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  fkat_sts_t sts,
  output fkat_cmd_t cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SCAN, S_CHECK, S_DONE, S_OUT
  } state_t;

  state_t          state;
  logic            action;
  logic [CntW-1:0] idx;
  logic [IdxW-1:0] cur;
  logic            have_free;
  logic [IdxW-1:0] free_idx;
  logic [TableDepth-1:0] valid_bits;
  logic            hit;

  assign in_ready = (state == S_IDLE);
  assign cur = idx[IdxW-1:0];
  assign hit = !action && sts.key_match;

  always_comb begin
    cmd = '0;
    cmd.load   = in_valid && in_ready;
    cmd.mul_hi = (state == S_MUL);
    cmd.rd_idx = cur;
    cmd.wr_idx = free_idx;
    case (state)
      S_SCAN: cmd.rd_en = (idx < CntW'(TableDepth)) && valid_bits[cur];
      S_CHECK: begin
        if (hit) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_idx     = cur;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_UPDATED;
        end else if (action) begin
          cmd.res_load     = 1'b1;
          cmd.res_status   = ST_DRAINED;
        end
      end
      S_DONE: begin
        cmd.res_load = 1'b1;
        if (action) cmd.res_status = ST_EMPTY;
        else if (have_free) begin
          cmd.res_status = ST_INSERTED;
          cmd.wr_en      = 1'b1;
          cmd.wr_insert  = 1'b1;
        end else cmd.res_status = ST_FULL;
      end
      default: ;
    endcase
  end

  // free entries are scanned one per cycle; a valid entry is read in S_SCAN, then checked in S_CHECK
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      out_valid  <= 1'b0;
      idx        <= '0;
      have_free  <= 1'b0;
      free_idx   <= '0;
      action     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          action    <= in_action;
          idx       <= '0;
          have_free <= 1'b0;
          state     <= S_MUL;
        end
        S_MUL: state <= S_SCAN;
        S_SCAN: begin
          if (idx == CntW'(TableDepth)) state <= S_DONE;
          else if (valid_bits[cur]) state <= S_CHECK;
          else begin
            if (!have_free) begin
              have_free <= 1'b1;
              free_idx  <= cur;
            end
            idx <= idx + 1'b1;
          end
        end
        S_CHECK: begin
          if (action) begin
            valid_bits[cur] <= 1'b0;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else if (hit) begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SCAN;
          end
        end
        S_DONE: begin
          if (!action && have_free) valid_bits[free_idx] <= 1'b1;
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[hdl/flow_key_aggregation_table.sv]
// Top level: flow key aggregation table with controller and datapath.
`timescale 1ns / 1ps
// Usage:
//   Items enter on the in_ch sink channel and one result per item leaves on
//   the out_ch source channel; a transfer happens when valid and ready are
//   both high at a rising clock edge.
//   action 0 aggregates a flow record into the entry with a matching key,
//   inserting into the lowest free entry or reporting full; action 1 drains
//   the lowest valid entry or reports empty.
//   Configuration: cfg_we with cfg_index 0 writes scale_a, 1 writes scale_b;
//   write only while the block is idle. Both reset to 1.
//   Scan: the scan walks free entries one per cycle and visits each valid
//   entry in S_SCAN and then S_CHECK; after the scan the result is
//   registered and out_ch valid rises, and in_ch ready returns once the
//   result transfer completes.
//   The scan stops early on a key match or on the first valid entry of a
//   drain. One item is in flight at a time; in_ch ready is high only idle.
//   Reset clears all valid bits at once; no clearing pass is needed.
//   A stalled receiver holds the result register and the block takes no new
//   item until the result transfer completes.
module flow_key_aggregation_table
  import fkat_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fkat_stream_if.sink   in_ch,
  fkat_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [31:0] scale_a, scale_b;
  fkat_cmd_t   cmd;
  fkat_sts_t   sts;

  // hold the scale registers; cfg_index selects scale_a or scale_b
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_a <= 32'd1;
      scale_b <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE_A: scale_a <= cfg_data;
        REG_SCALE_B: scale_b <= cfg_data;
        default: ;
      endcase
    end
  end

  fkat_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.data.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fkat_datapath u_dp (
    .clk     (clk),
    .item    (in_ch.data),
    .scale_a (scale_a),
    .scale_b (scale_b),
    .cmd     (cmd),
    .sts     (sts),
    .result  (out_ch.data)
  );
endmodule

[sim/tb_flow_key_aggregation_table.sv]
// Testbench: directed and random flow records and drains checked against a table predictor.
`timescale 1ns / 1ps
module tb_flow_key_aggregation_table;
  import fkat_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_SCALE_A;
  logic [31:0] cfg_data = '0;

  fkat_stream_if #(.payload_t(item_t))   in_ch ();
  fkat_stream_if #(.payload_t(result_t)) out_ch ();

  flow_key_aggregation_table i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor copy of the table and the scale registers.
  localparam int Depth = TableDepth;
  logic [31:0] pred_scale_a, pred_scale_b;
  logic        tbl_valid [Depth];
  logic [63:0] tbl_key_high [Depth];
  logic [63:0] tbl_key_low [Depth];
  logic [63:0] tbl_total_a [Depth];
  logic [63:0] tbl_total_b [Depth];

  result_t expected_results[$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_off_cycles = 0;

  // Mirror one accepted item into the table and queue its result.
  function automatic void predict_table_step(item_t it);
    result_t r;
    logic [63:0] da, db;
    int free_idx;
    r = '0;
    da = it.value_a * {32'd0, pred_scale_a};
    db = it.value_b * {32'd0, pred_scale_b};
    free_idx = -1;
    if (it.action) begin
      r.status = ST_EMPTY;
      for (int i = 0; i < Depth; i++) begin
        if (tbl_valid[i]) begin
          tbl_valid[i] = 1'b0;
          r = '{ST_DRAINED, tbl_key_high[i], tbl_key_low[i], tbl_total_a[i],
                tbl_total_b[i]};
          break;
        end
      end
      expected_results.push_back(r);
      return;
    end
    for (int i = 0; i < Depth; i++) begin
      if (tbl_valid[i]) begin
        if (tbl_key_high[i] == it.key_high && tbl_key_low[i] == it.key_low) begin
          tbl_total_a[i] += da;
          tbl_total_b[i] += db;
          r = '{ST_UPDATED, it.key_high, it.key_low, tbl_total_a[i], tbl_total_b[i]};
          expected_results.push_back(r);
          return;
        end
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (free_idx < 0) begin
      r = '{ST_FULL, it.key_high, it.key_low, 64'd0, 64'd0};
    end else begin
      tbl_valid[free_idx] = 1'b1;
      tbl_key_high[free_idx] = it.key_high;
      tbl_key_low[free_idx] = it.key_low;
      tbl_total_a[free_idx] = da;
      tbl_total_b[free_idx] = db;
      r = '{ST_INSERTED, it.key_high, it.key_low, da, db};
    end
    expected_results.push_back(r);
  endfunction

  // Offer one item at the falling edge, hold until the transfer.
  task automatic send_item(item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_table_step(it);
    @(negedge clk);
  endtask

  // Sample results at the rising edge and compare field by field.
  always @(posedge clk) begin
    result_t got, exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.status !== exp_r.status)
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
        if (got.out_key_high !== exp_r.out_key_high)
          $display("%0t: key_high exp %h got %h", $time, exp_r.out_key_high,
                   got.out_key_high);
        if (got.out_key_low !== exp_r.out_key_low)
          $display("%0t: key_low exp %h got %h", $time, exp_r.out_key_low,
                   got.out_key_low);
        if (got.total_a !== exp_r.total_a)
          $display("%0t: total_a exp %h got %h", $time, exp_r.total_a, got.total_a);
        if (got.total_b !== exp_r.total_b)
          $display("%0t: total_b exp %h got %h", $time, exp_r.total_b, got.total_b);
        if (got !== exp_r) errors++;
      end
    end
  end

  // Receiver ready: random stalls, or a long hold-off counted here.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Drop the offer, wait for every expected result, then let the block settle.
  task automatic drain_expected();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_scale(logic [0:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_SCALE_A) pred_scale_a = val;
    else pred_scale_b = val;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic item_t flow_item(logic [63:0] kh, logic [63:0] kl,
                                      logic [63:0] va, logic [63:0] vb);
    return '{1'b0, kh, kl, va, vb};
  endfunction

  function automatic item_t drain_item();
    return '{1'b1, rand64(), rand64(), rand64(), rand64()};
  endfunction

  // Directed: empty drain, insert, update with wrap, extremes, drain order.
  task automatic test_directed();
    send_item(drain_item());
    send_item(flow_item('1, '1, '1, '1));
    send_item(flow_item('1, '1, 64'd1, 64'd2));
    send_item(flow_item('0, '0, '0, '0));
    send_item(flow_item('0, 64'd1, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555));
    send_item(flow_item(64'd1, '0, 64'hAAAA_AAAA_AAAA_AAAA, 64'd7));
    send_item(drain_item());
    send_item(flow_item('0, 64'd1, 64'd3, 64'd4));
    send_item(flow_item('1, '1, 64'd9, 64'd9));
    repeat (4) send_item(drain_item());
    drain_expected();
    write_scale(REG_SCALE_A, 32'hFFFF_FFFF);
    write_scale(REG_SCALE_B, 32'd0);
    send_item(flow_item(64'h1234, 64'h5678, '1, '1));
    send_item(flow_item(64'h1234, 64'h5678, 64'hFFFF_FFFF_0000_0001, 64'd5));
    send_item(drain_item());
    drain_expected();
  endtask

  // Fill the table past depth to reach the full status, then drain half of it.
  task automatic test_full_table();
    write_scale(REG_SCALE_A, 32'd3);
    write_scale(REG_SCALE_B, 32'h8000_0000);
    for (int i = 0; i < Depth + 3; i++)
      send_item(flow_item(rand64(), 64'(i), rand64(), rand64()));
    send_item(flow_item('0, 64'd5, 64'd1, 64'd1)); // new key on a full table
    for (int i = 0; i < Depth / 2; i++) send_item(drain_item());
    drain_expected();
  endtask

  // Random mix over a small key pool so updates are common.
  task automatic test_random(int count);
    item_t it;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 20) begin
        it = drain_item();
      end else begin
        it = flow_item({60'd0, 4'($urandom_range(15))}, {56'd0, 8'($urandom_range(11))},
                       rand64(), rand64());
        if ($urandom_range(9) == 0) begin
          it.key_high = rand64();
          it.key_low = rand64();
        end
        if ($urandom_range(3) == 0) it.value_a = 64'($urandom_range(3));
      end
      send_item(it);
    end
    drain_expected();
  endtask

  // Long receiver hold-off while items keep being offered.
  task automatic test_backpressure();
    hold_off_cycles = 3000;
    for (int n = 0; n < 12; n++)
      send_item(flow_item(64'd77, 64'($urandom_range(5)), rand64(), rand64()));
    drain_expected();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b1;
    pred_scale_a = 32'd1;
    pred_scale_b = 32'd1;
    for (int i = 0; i < Depth; i++) tbl_valid[i] = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_full_table();
    write_scale(REG_SCALE_A, 32'd1);
    write_scale(REG_SCALE_B, 32'd1);
    test_random(20);
    write_scale(REG_SCALE_A, 32'($urandom()));
    write_scale(REG_SCALE_B, 32'($urandom()));
    send_idle_pct = 52;
    test_random(20);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    write_scale(REG_SCALE_A, 32'd0);
    write_scale(REG_SCALE_B, 32'hFFFF_FFFF);
    test_random(20);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    write_scale(REG_SCALE_A, 32'($urandom()));
    test_random(20);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();

    if (errors == 0 && expected_results.size() == 0) begin
      $display("flow_key_aggregation_table: match");
    end else begin
      $display("flow_key_aggregation_table: mismatch");
    end
    $finish;
  end

  // Timeout: bounds about 500 items plus receiver stalls.
  initial begin
    #40_000_000;
    $display("flow_key_aggregation_table: mismatch");
    $finish;
  end
endmodule

[flow_key_aggregation_table.f]
hdl/fkat_pkg.sv
hdl/fkat_stream_if.sv
hdl/fkat_datapath.sv
hdl/fkat_controller.sv
hdl/flow_key_aggregation_table.sv
sim/tb_flow_key_aggregation_table.sv
